// File: design/sit_pkg.sv
// Shared types and defaults for the segment intersection test core.
// No dependencies; used by sit_sign_unit and segment_intersection_test_core.
package sit_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // Kind of two-product form evaluated by a sign unit
    typedef enum logic {
        OP_CROSS,   // ux*vy - uy*vx
        OP_DOT      // ux*vx + uy*vy
    } op_t;

    // Sign of a wide sum: negative, zero, or (neither) positive
    typedef struct packed {
        logic neg;
        logic zero;
    } sign_t;

    // Load strobes for the two pipeline stages inside a sign unit
    typedef struct packed {
        logic mul;
        logic sum;
    } stage_en_t;

endpackage

// File: design/segment_intersection_test_core.sv
// Top level of the segment intersection test: stream ports and a four-stage pipeline.
// Depends on sit_pkg and sit_sign_unit.

// Each input beat carries two closed segments AB and CD as signed coordinates and
// yields one result beat whose bit 0 is 1 when the segments share a point. The core
// takes one beat per clock while m_tready keeps the output moving. The four register
// stages (differences, products, signs, decision) are loaded in that order, each one
// when the stage ahead can take its beat, and the result can be taken while m_tready
// is high; every stage has its own valid bit, so a stalled output holds its beat
// while empty stages upstream keep filling. All arithmetic is exact integer math:
// coordinate differences are COORD_WIDTH+1 bits, the ten cross and dot forms are
// built from twenty registered multipliers, and only the signs of their sums are
// kept. Collinear pairs are resolved from endpoint equality and three dot signs.
// s_tdata packs ax, ay, bx, by, cx, cy, dx, dy, COORD_WIDTH bits each, from bit 0 up.
module segment_intersection_test_core #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // ax, ay, bx, by, cx, cy, dx, dy (lowest bit up), COORD_WIDTH bits each
    input  logic [8*COORD_WIDTH-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // intersects in bit 0, bits 7:1 zero
    output logic [7:0]                 m_tdata
);
    import sit_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;

    // Input fields
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    assign ax = s_tdata[0*CW +: CW];
    assign ay = s_tdata[1*CW +: CW];
    assign bx = s_tdata[2*CW +: CW];
    assign by = s_tdata[3*CW +: CW];
    assign cx = s_tdata[4*CW +: CW];
    assign cy = s_tdata[5*CW +: CW];
    assign dx = s_tdata[6*CW +: CW];
    assign dy = s_tdata[7*CW +: CW];

    // Stage valid bits and per-stage ready chain
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic out_valid_reg, out_valid_next;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = ~out_valid_reg | m_tready;
    assign rdy3 = ~v3_reg | rdy4;
    assign rdy2 = ~v2_reg | rdy3;
    assign rdy1 = ~v1_reg | rdy2;
    assign s_tready = rdy1;

    // Stage 1: differences and endpoint equality
    logic signed [DW-1:0] ba_x_reg, ba_y_reg, cd_x_reg, cd_y_reg, ca_x_reg, ca_y_reg;
    logic signed [DW-1:0] cb_x_reg, cb_y_reg, da_x_reg, da_y_reg, db_x_reg, db_y_reg;
    logic signed [DW-1:0] ba_x_next, ba_y_next, cd_x_next, cd_y_next, ca_x_next, ca_y_next;
    logic signed [DW-1:0] cb_x_next, cb_y_next, da_x_next, da_y_next, db_x_next, db_y_next;
    logic eq1_reg, eq1_next, eq2_reg, eq3_reg;

    always_comb begin
        ba_x_next = DW'(bx) - DW'(ax);
        ba_y_next = DW'(by) - DW'(ay);
        cd_x_next = DW'(cx) - DW'(dx);
        cd_y_next = DW'(cy) - DW'(dy);
        ca_x_next = DW'(cx) - DW'(ax);
        ca_y_next = DW'(cy) - DW'(ay);
        cb_x_next = DW'(cx) - DW'(bx);
        cb_y_next = DW'(cy) - DW'(by);
        da_x_next = DW'(dx) - DW'(ax);
        da_y_next = DW'(dy) - DW'(ay);
        db_x_next = DW'(dx) - DW'(bx);
        db_y_next = DW'(dy) - DW'(by);
        // any endpoint of AB on any endpoint of CD
        eq1_next  = (ax == cx && ay == cy) || (ax == dx && ay == dy) ||
                    (bx == cx && by == cy) || (bx == dx && by == dy);
    end

    logic ld1, ld2, ld3, ld4;
    assign ld1 = s_tvalid & rdy1;
    assign ld2 = v1_reg & rdy2;
    assign ld3 = v2_reg & rdy3;
    assign ld4 = v3_reg & rdy4;

    always_ff @(posedge aclk) begin
        if (ld1) begin
            ba_x_reg <= ba_x_next;  ba_y_reg <= ba_y_next;
            cd_x_reg <= cd_x_next;  cd_y_reg <= cd_y_next;
            ca_x_reg <= ca_x_next;  ca_y_reg <= ca_y_next;
            cb_x_reg <= cb_x_next;  cb_y_reg <= cb_y_next;
            da_x_reg <= da_x_next;  da_y_reg <= da_y_next;
            db_x_reg <= db_x_next;  db_y_reg <= db_y_next;
            eq1_reg  <= eq1_next;
        end
        // carry the equality flag alongside the sign units
        if (ld2) begin
            eq2_reg <= eq1_reg;
        end
        if (ld3) begin
            eq3_reg <= eq2_reg;
        end
    end

    // Stages 2 and 3: products, then signs, inside the sign units
    stage_en_t en;
    assign en.mul = ld2;
    assign en.sum = ld3;

    sign_t c1, c2, c3, d1, d2, d3, s1, s2, s3, s4;

    // collinearity: cross(B-A, C-D), cross(A-B, A-C), cross(C-D, C-A)
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_CROSS)) u_c1 (
        .aclk(aclk), .en(en), .ux(ba_x_reg), .uy(ba_y_reg),
        .vx(cd_x_reg), .vy(cd_y_reg), .sign(c1));
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_CROSS)) u_c2 (
        .aclk(aclk), .en(en), .ux(ba_x_reg), .uy(ba_y_reg),
        .vx(ca_x_reg), .vy(ca_y_reg), .sign(c2));
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_CROSS)) u_c3 (
        .aclk(aclk), .en(en), .ux(cd_x_reg), .uy(cd_y_reg),
        .vx(ca_x_reg), .vy(ca_y_reg), .sign(c3));

    // collinear overlap: dot(C-A, C-B), dot(D-A, D-B), dot(C-B, D-B)
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_DOT)) u_d1 (
        .aclk(aclk), .en(en), .ux(ca_x_reg), .uy(ca_y_reg),
        .vx(cb_x_reg), .vy(cb_y_reg), .sign(d1));
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_DOT)) u_d2 (
        .aclk(aclk), .en(en), .ux(da_x_reg), .uy(da_y_reg),
        .vx(db_x_reg), .vy(db_y_reg), .sign(d2));
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_DOT)) u_d3 (
        .aclk(aclk), .en(en), .ux(cb_x_reg), .uy(cb_y_reg),
        .vx(db_x_reg), .vy(db_y_reg), .sign(d3));

    // straddle tests: C, D against line AB; A, B against line CD
    // (negated operand pairs cancel, so A-C, D-C become C-A, C-D)
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_CROSS)) u_s1 (
        .aclk(aclk), .en(en), .ux(da_x_reg), .uy(da_y_reg),
        .vx(ba_x_reg), .vy(ba_y_reg), .sign(s1));
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_CROSS)) u_s2 (
        .aclk(aclk), .en(en), .ux(ca_x_reg), .uy(ca_y_reg),
        .vx(ba_x_reg), .vy(ba_y_reg), .sign(s2));
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_CROSS)) u_s3 (
        .aclk(aclk), .en(en), .ux(ca_x_reg), .uy(ca_y_reg),
        .vx(cd_x_reg), .vy(cd_y_reg), .sign(s3));
    sit_sign_unit #(.COORD_WIDTH(COORD_WIDTH), .OP(OP_CROSS)) u_s4 (
        .aclk(aclk), .en(en), .ux(cb_x_reg), .uy(cb_y_reg),
        .vx(cd_x_reg), .vy(cd_y_reg), .sign(s4));

    // Stage 4: decision
    logic coll, dots_pos, same12, same34;
    logic hit_reg, hit_next;

    always_comb begin
        coll     = c1.zero & c2.zero & c3.zero;
        dots_pos = ~d1.neg & ~d1.zero & ~d2.neg & ~d2.zero & ~d3.neg & ~d3.zero;
        // both strictly on one side: nonzero and equal sign
        same12   = ~s1.zero & ~s2.zero & (s1.neg == s2.neg);
        same34   = ~s3.zero & ~s4.zero & (s3.neg == s4.neg);
        if (coll) begin
            hit_next = eq3_reg | ~dots_pos;
        end else begin
            hit_next = ~(same12 | same34);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            hit_reg <= hit_next;
        end
    end

    // Valid bits advance when the stage ahead can take the beat
    always_comb begin
        v1_next        = rdy1 ? s_tvalid : v1_reg;
        v2_next        = rdy2 ? v1_reg   : v2_reg;
        v3_next        = rdy3 ? v2_reg   : v3_reg;
        out_valid_next = rdy4 ? v3_reg   : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, hit_reg};

endmodule

// File: design/sit_sign_unit.sv
// Two-stage sign unit: registered products, then registered sign of their sum or difference.
// Depends on sit_pkg (op_t, sign_t, stage_en_t).
module sit_sign_unit #(
    parameter int          COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF,
    parameter sit_pkg::op_t OP         = sit_pkg::OP_CROSS
) (
    input  logic                     aclk,
    input  sit_pkg::stage_en_t       en,
    input  logic signed [COORD_WIDTH:0] ux,
    input  logic signed [COORD_WIDTH:0] uy,
    input  logic signed [COORD_WIDTH:0] vx,
    input  logic signed [COORD_WIDTH:0] vy,
    output sit_pkg::sign_t           sign
);
    import sit_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [DW-1:0] op1;
    logic signed [DW-1:0] op2;
    logic signed [PW-1:0] p1_reg, p1_next;
    logic signed [PW-1:0] p2_reg, p2_next;
    logic signed [SW-1:0] sum;
    sign_t                sign_reg, sign_next;

    // cross pairs ux with vy, dot pairs ux with vx
    assign op1 = (OP == OP_CROSS) ? vy : vx;
    assign op2 = (OP == OP_CROSS) ? vx : vy;

    always_comb begin
        p1_next = ux * op1;
        p2_next = uy * op2;
    end

    always_comb begin
        if (OP == OP_CROSS) begin
            sum = SW'(p1_reg) - SW'(p2_reg);
        end else begin
            sum = SW'(p1_reg) + SW'(p2_reg);
        end
        sign_next.neg  = sum[SW-1];
        sign_next.zero = (sum == '0);
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (en.sum) begin
            sign_reg <= sign_next;
        end
    end

    assign sign = sign_reg;

endmodule
